@@ hw/rtl/fifo_ready_queue_scheduler_core_assert.svh @@
// assertion macros of the scheduler rtl
`ifndef FIFO_READY_QUEUE_SCHEDULER_CORE_ASSERT_SVH
`define FIFO_READY_QUEUE_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define FRQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frq assertion failed");

// next-cycle implication, disabled while in reset
`define FRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frq assertion failed");

`endif

@@ hw/rtl/frq_pkg.sv @@
// types and constants of the ready queue scheduler
`timescale 1ns / 1ps

package frq_pkg;

    // fixed field widths of the channels
    localparam int FIELD_W  = 8;
    localparam int ACT_W    = 2;
    localparam int STATUS_W = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ENQUEUE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_YIELD      = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TERM_OTHER = 2'd2;
    localparam logic [ACT_W-1:0] ACT_TERM_SELF  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_IDLE = 2'd2;

    // command broadcast to every cell of the queue
    typedef struct packed {
        logic remove_en;  // drop the first matching entry, later cells move up
        logic match_any;  // every occupied entry matches (pop the head)
        logic load_en;    // write the tail cell
    } frq_cell_cmd_t;

endpackage

@@ hw/rtl/frq_if.sv @@
// valid/ready channel interfaces of the scheduler
`timescale 1ns / 1ps

interface frq_item_if;
    import frq_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [FIELD_W-1:0]  thread_id;
    logic [FIELD_W-1:0]  current_id;
    modport source (output valid, action, thread_id, current_id, input ready);
    modport sink   (input valid, action, thread_id, current_id, output ready);
endinterface

interface frq_result_if;
    import frq_pkg::*;
    logic                valid;
    logic                ready;
    logic                dispatch_valid;
    logic [FIELD_W-1:0]  next_thread;
    logic                was_removed;
    logic [STATUS_W-1:0] status;
    modport source (output valid, dispatch_valid, next_thread, was_removed, status,
                    input ready);
    modport sink   (input valid, dispatch_valid, next_thread, was_removed, status,
                    output ready);
endinterface

interface frq_cfg_if;
    import frq_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/frq_cell.sv @@
// one queue cell: holds one entry, shifts up from its neighbour on removal
`timescale 1ns / 1ps

module frq_cell #(
    parameter int IDX   = 0,
    parameter int ID_W  = 8,
    parameter int CNT_W = 5
) (
    input  logic                  clk,
    input  logic                  step,
    input  frq_pkg::frq_cell_cmd_t cmd,
    input  logic [CNT_W-1:0]      count,
    input  logic [ID_W-1:0]       key,
    input  logic [ID_W-1:0]       load_data,
    input  logic [ID_W-1:0]       next_entry,
    input  logic                  found_in,
    output logic                  found_out,
    output logic [ID_W-1:0]       entry
);
    import frq_pkg::*;

    logic [ID_W-1:0] entry_reg;
    logic [ID_W-1:0] entry_next;
    logic            occupied;
    logic            match;
    logic            shift_up;

    // match on an occupied cell, carried to the cells behind it
    assign occupied  = (count > CNT_W'(IDX));
    assign match     = occupied && (cmd.match_any || (entry_reg == key));
    assign shift_up  = found_in || match;
    assign found_out = shift_up;

    // entry update: take the neighbour's entry at and after the removed one
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.remove_en && shift_up)
        begin
            entry_next = next_entry;
        end
        else if (cmd.load_en && (count == CNT_W'(IDX)))
        begin
            entry_next = load_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

@@ hw/rtl/frq_cell_chain.sv @@
// row of queue cells, head at cell zero
`timescale 1ns / 1ps

module frq_cell_chain #(
    parameter int DEPTH = 16,
    parameter int ID_W  = 8,
    parameter int CNT_W = 5
) (
    input  logic                   clk,
    input  logic                   step,
    input  frq_pkg::frq_cell_cmd_t cmd,
    input  logic [CNT_W-1:0]       count,
    input  logic [ID_W-1:0]        key,
    input  logic [ID_W-1:0]        load_data,
    output logic [ID_W-1:0]        head,
    output logic                   found
);
    import frq_pkg::*;

    logic [ID_W-1:0] ent [DEPTH];
    logic [DEPTH:0]  found_chain;

    assign found_chain[0] = 1'b0;

    // cells, each fed by the one behind it, the last one by itself
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ID_W-1:0] behind;
        if (i == DEPTH - 1)
        begin : g_last
            assign behind = ent[i];
        end
        else
        begin : g_mid
            assign behind = ent[i+1];
        end

        frq_cell #(
            .IDX   (i),
            .ID_W  (ID_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .step       (step),
            .cmd        (cmd),
            .count      (count),
            .key        (key),
            .load_data  (load_data),
            .next_entry (behind),
            .found_in   (found_chain[i]),
            .found_out  (found_chain[i+1]),
            .entry      (ent[i])
        );
    end

    assign head  = ent[0];
    assign found = found_chain[DEPTH];

endmodule

@@ hw/rtl/fifo_ready_queue_scheduler_core.sv @@
// top level of the fifo ready queue thread scheduler
`timescale 1ns / 1ps

// FIFO ready-queue scheduler. The ready queue is a row of QUEUE_DEPTH cells with
// the head in cell zero; a removal moves every later entry one cell up in one
// queue update. One scheduling action is handled at a time. Enqueue, yield and
// terminate-other go through the input transfer (S_IDLE), then one queue update
// that also loads the result register (S_EXEC); terminate-self does its two
// removals (the running thread in S_EXEC, then the head in S_POP) in successive
// states. The input is ready again in the cycle after the result is written, so
// no new action is taken before the last one is through; a stalled result
// register holds the final step. idle_id is written through the cfg channel,
// which is always ready.
module fifo_ready_queue_scheduler_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic   clk,
    input  logic   rst_n,
    frq_item_if.sink     item_in,
    frq_result_if.source result_out,
    frq_cfg_if.sink      cfg
);
    import frq_pkg::*;

`include "fifo_ready_queue_scheduler_core_assert.svh"

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [ACT_W-1:0]    act_reg;
    logic [ID_BITS-1:0]  tid_reg;
    logic [ID_BITS-1:0]  cur_reg;
    logic [ID_BITS-1:0]  idle_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ID_BITS-1:0]  yid_reg;
    logic                yvalid_reg;
    logic                rm_hold_reg;
    logic                out_valid_reg, out_valid_next;
    logic                out_dv_reg;
    logic [ID_BITS-1:0]  out_nt_reg;
    logic                out_rm_reg;
    logic [STATUS_W-1:0] out_st_reg;

    frq_cell_cmd_t       cmd;
    logic [ID_BITS-1:0]  key;
    logic [ID_BITS-1:0]  head;
    logic                found;
    logic                out_free;
    logic                finish;
    logic                step;
    logic                self_first;
    logic                queue_empty;
    logic                res_dv;
    logic [ID_BITS-1:0]  res_nt;
    logic                res_rm;
    logic [STATUS_W-1:0] res_st;
    logic                take_yield;

    // handshakes
    assign item_in.ready = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign out_free      = !out_valid_reg || result_out.ready;
    assign queue_empty   = (count_reg == '0);
    assign self_first    = (state_reg == S_EXEC) && (act_reg == ACT_TERM_SELF);
    assign finish        = out_free && (((state_reg == S_EXEC) && !self_first)
                                        || (state_reg == S_POP));
    assign step          = finish || self_first;

    // queue command and result of the current step
    always_comb
    begin
        cmd        = '0;
        key        = cur_reg;
        res_dv     = 1'b0;
        res_nt     = '0;
        res_rm     = 1'b0;
        res_st     = STATUS_OK;
        take_yield = 1'b0;
        if (state_reg == S_POP)
        begin
            cmd.remove_en = 1'b1;
            cmd.match_any = 1'b1;
            res_dv        = 1'b1;
            res_rm        = rm_hold_reg;
            if (!queue_empty)
            begin
                res_nt = head;
            end
            else if (yvalid_reg)
            begin
                res_nt = yid_reg;
            end
            else
            begin
                res_nt = idle_reg;
            end
        end
        else if (state_reg == S_EXEC)
        begin
            case (act_reg)
                ACT_ENQUEUE:
                begin
                    if (tid_reg == idle_reg)
                    begin
                        res_st = STATUS_IDLE;
                    end
                    else if (count_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        res_st = STATUS_FULL;
                    end
                    else
                    begin
                        cmd.load_en = 1'b1;
                    end
                end
                ACT_YIELD:
                begin
                    cmd.remove_en = 1'b1;
                    cmd.match_any = 1'b1;
                    take_yield    = 1'b1;
                    res_dv        = !queue_empty;
                    res_nt        = queue_empty ? cur_reg : head;
                end
                ACT_TERM_OTHER:
                begin
                    key = tid_reg;
                    if (tid_reg == idle_reg)
                    begin
                        res_st = STATUS_IDLE;
                    end
                    else
                    begin
                        cmd.remove_en = 1'b1;
                        res_rm        = found;
                    end
                end
                default:
                begin
                    cmd.remove_en = 1'b1;
                end
            endcase
        end
    end

    // queue occupancy
    always_comb
    begin
        count_next = count_reg;
        if (step && cmd.remove_en && found)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (step && cmd.load_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_in.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (self_first)
                begin
                    state_next = S_POP;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            yid_reg       <= '0;
            yvalid_reg    <= 1'b0;
            idle_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                idle_reg <= ID_BITS'(cfg.data);
            end
            if (finish && take_yield)
            begin
                yid_reg    <= cur_reg;
                yvalid_reg <= 1'b1;
            end
        end
    end

    // captured item, held removal flag and result payload
    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            act_reg <= item_in.action;
            tid_reg <= ID_BITS'(item_in.thread_id);
            cur_reg <= ID_BITS'(item_in.current_id);
        end
        if (self_first)
        begin
            rm_hold_reg <= found;
        end
        if (finish)
        begin
            out_dv_reg <= res_dv;
            out_nt_reg <= res_nt;
            out_rm_reg <= res_rm;
            out_st_reg <= res_st;
        end
    end

    // ready queue
    frq_cell_chain #(
        .DEPTH (QUEUE_DEPTH),
        .ID_W  (ID_BITS),
        .CNT_W (CNT_W)
    ) u_chain (
        .clk       (clk),
        .step      (step),
        .cmd       (cmd),
        .count     (count_reg),
        .key       (key),
        .load_data (tid_reg),
        .head      (head),
        .found     (found)
    );

    assign result_out.valid          = out_valid_reg;
    assign result_out.dispatch_valid = out_dv_reg;
    assign result_out.next_thread    = FIELD_W'(out_nt_reg);
    assign result_out.was_removed    = out_rm_reg;
    assign result_out.status         = out_st_reg;

    // checks
    `FRQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `FRQ_ASSERT_NEXT(a_accept_exec, clk, rst_n, item_in.valid && item_in.ready, state_reg == S_EXEC)
    `FRQ_ASSERT_NEXT(a_enq_grows, clk, rst_n, finish && cmd.load_en, count_reg == $past(count_reg) + CNT_W'(1))
    `FRQ_ASSERT_NEXT(a_self_dispatch, clk, rst_n, finish && (act_reg == ACT_TERM_SELF), out_dv_reg)

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench of the fifo ready queue scheduler
`timescale 1ns / 1ps

module tb_top;
    import frq_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int RAND_PHASES = 7;
    localparam int PHASE_ITEMS = 200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;

    // one scheduling action as it crosses the input channel
    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [FIELD_W-1:0] thread_id;
        logic [FIELD_W-1:0] current_id;
    } sched_action_t;

    // one scheduler answer
    typedef struct packed {
        logic                dispatch_valid;
        logic [FIELD_W-1:0]  next_thread;
        logic                was_removed;
        logic [STATUS_W-1:0] status;
    } sched_answer_t;

    // directed row: action plus an answer typed in where it is obvious
    typedef struct packed {
        sched_action_t act;
        logic          typed;
        sched_answer_t answer;
    } sched_row_t;

    // directed rows, idle thread at its reset value of zero
    localparam int DIR_ROWS = 26;
    sched_row_t dir_rows [DIR_ROWS] = '{
        '{'{ACT_TERM_SELF,  8'h00, 8'h55}, 1'b1, '{1'b1, 8'h00, 1'b0, STATUS_OK}},
        '{'{ACT_ENQUEUE,    8'h00, 8'h00}, 1'b1, '{1'b0, 8'h00, 1'b0, STATUS_IDLE}},
        '{'{ACT_TERM_OTHER, 8'h00, 8'hFF}, 1'b1, '{1'b0, 8'h00, 1'b0, STATUS_IDLE}},
        '{'{ACT_TERM_OTHER, 8'h33, 8'h00}, 1'b1, '{1'b0, 8'h00, 1'b0, STATUS_OK}},
        '{'{ACT_YIELD,      8'h00, 8'hFF}, 1'b1, '{1'b0, 8'hFF, 1'b0, STATUS_OK}},
        '{'{ACT_TERM_SELF,  8'hFF, 8'h12}, 1'b1, '{1'b1, 8'hFF, 1'b0, STATUS_OK}},
        '{'{ACT_ENQUEUE,    8'hFF, 8'h00}, 1'b0, '0},
        '{'{ACT_ENQUEUE,    8'h01, 8'hFF}, 1'b0, '0},
        '{'{ACT_ENQUEUE,    8'h80, 8'h00}, 1'b0, '0},
        '{'{ACT_ENQUEUE,    8'h7F, 8'hFF}, 1'b0, '0},
        '{'{ACT_ENQUEUE,    8'h12, 8'h00}, 1'b0, '0},
        '{'{ACT_ENQUEUE,    8'h12, 8'hFF}, 1'b0, '0},
        '{'{ACT_ENQUEUE,    8'hAA, 8'h00}, 1'b0, '0},
        '{'{ACT_ENQUEUE,    8'h55, 8'hFF}, 1'b0, '0},
        '{'{ACT_ENQUEUE,    8'hFE, 8'h00}, 1'b0, '0},
        '{'{ACT_ENQUEUE,    8'h02, 8'hFF}, 1'b0, '0},
        '{'{ACT_ENQUEUE,    8'h40, 8'h00}, 1'b0, '0},
        '{'{ACT_ENQUEUE,    8'h20, 8'hFF}, 1'b0, '0},
        '{'{ACT_ENQUEUE,    8'h10, 8'h00}, 1'b0, '0},
        '{'{ACT_ENQUEUE,    8'h08, 8'hFF}, 1'b0, '0},
        '{'{ACT_ENQUEUE,    8'h04, 8'h00}, 1'b0, '0},
        '{'{ACT_ENQUEUE,    8'h12, 8'hFF}, 1'b0, '0},
        '{'{ACT_ENQUEUE,    8'h9C, 8'h00}, 1'b1, '{1'b0, 8'h00, 1'b0, STATUS_FULL}},
        '{'{ACT_TERM_OTHER, 8'h12, 8'h00}, 1'b0, '0},
        '{'{ACT_YIELD,      8'h00, 8'h12}, 1'b0, '0},
        '{'{ACT_TERM_SELF,  8'h00, 8'h12}, 1'b0, '0}
    };

    // idle thread and enqueue share per random phase
    localparam logic [FIELD_W-1:0] PHASE_IDLE [RAND_PHASES] =
        '{8'hFF, 8'h00, 8'h5A, 8'h80, 8'h01, 8'h13, 8'hFE};
    localparam int PHASE_ENQ_PCT [RAND_PHASES] = '{70, 35, 55, 80, 30, 50, 60};

    logic clk = 1'b0;
    logic rst_n;

    frq_item_if   item_if ();
    frq_result_if res_if ();
    frq_cfg_if    cfg_if ();

    fifo_ready_queue_scheduler_core #(
        .QUEUE_DEPTH (QDEPTH),
        .ID_BITS     (FIELD_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (res_if),
        .cfg        (cfg_if)
    );

    // mirror of the scheduler state
    logic [FIELD_W-1:0] ready_q [$];
    logic [FIELD_W-1:0] yield_tid;
    logic               yielder_seen;
    logic [FIELD_W-1:0] idle_tid;

    sched_answer_t answers_due [$];

    int fail_cnt     = 0;
    int cycle_cnt    = 0;
    int checked_cnt  = 0;
    int burst_left   = 0;
    int full_drops   = 0;
    int idle_ignores = 0;
    int cfg_writes   = 0;
    int act_cnt [4]  = '{0, 0, 0, 0};

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // drop the first queue entry that matches, report whether one was found
    function automatic logic drop_first(input logic [FIELD_W-1:0] id);
        for (int i = 0; i < ready_q.size(); i++)
        begin
            if (ready_q[i] == id)
            begin
                ready_q.delete(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // next state and answer of the scheduler for one action
    function automatic sched_answer_t schedule_action(input sched_action_t a);
        sched_answer_t ans;
        ans = '0;
        ans.status = STATUS_OK;
        case (a.action)
            ACT_ENQUEUE:
            begin
                if (a.thread_id == idle_tid)
                    ans.status = STATUS_IDLE;
                else if (ready_q.size() >= QDEPTH)
                    ans.status = STATUS_FULL;
                else
                    ready_q.push_back(a.thread_id);
            end
            ACT_YIELD:
            begin
                yield_tid = a.current_id;
                yielder_seen = 1'b1;
                if (ready_q.size() > 0)
                begin
                    ans.dispatch_valid = 1'b1;
                    ans.next_thread    = ready_q.pop_front();
                end
                else
                    ans.next_thread = a.current_id;
            end
            ACT_TERM_OTHER:
            begin
                if (a.thread_id == idle_tid)
                    ans.status = STATUS_IDLE;
                else
                    ans.was_removed = drop_first(a.thread_id);
            end
            default:
            begin
                ans.was_removed    = drop_first(a.current_id);
                ans.dispatch_valid = 1'b1;
                if (ready_q.size() > 0)
                    ans.next_thread = ready_q.pop_front();
                else if (yielder_seen)
                begin
                    void'(drop_first(yield_tid));
                    ans.next_thread = yield_tid;
                end
                else
                    ans.next_thread = idle_tid;
            end
        endcase
        return ans;
    endfunction

    // random thread id, biased towards queued threads, the idle thread and a small pool
    function automatic logic [FIELD_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25 && ready_q.size() > 0)
            return ready_q[$urandom_range(0, ready_q.size() - 1)];
        if (r < 35)
            return idle_tid;
        if (r < 75)
            return 8'h10 + FIELD_W'($urandom_range(0, 7));
        return FIELD_W'($urandom_range(0, 255));
    endfunction

    // send one action in bursts with random gaps; entered and left at a falling edge
    task automatic send_action(input sched_action_t a, input logic typed,
                               input sched_answer_t typed_ans);
        int gap;
        sched_answer_t ans;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        item_if.valid      <= 1'b1;
        item_if.action     <= a.action;
        item_if.thread_id  <= a.thread_id;
        item_if.current_id <= a.current_id;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        // transfer taken: predict at once
        ans = schedule_action(a);
        if (ans.status == STATUS_FULL)
            full_drops++;
        if (ans.status == STATUS_IDLE)
            idle_ignores++;
        act_cnt[a.action]++;
        answers_due.push_back(typed ? typed_ans : ans);
        burst_left--;
        @(negedge clk);
    endtask

    // stop sending and wait until every answer is back and the block has settled
    task automatic drain_block();
        item_if.valid <= 1'b0;
        burst_left = 0;
        while (answers_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // write the idle thread register; entered and left at a falling edge
    task automatic write_idle(input logic [FIELD_W-1:0] id);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= id;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        idle_tid = id;
        cfg_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    // result side stalls in stretches of its own
    initial
    begin
        int stretch;
        int ready_pct;
        stretch   = 0;
        ready_pct = 100;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stretch == 0)
            begin
                case ($urandom_range(0, 3))
                    0, 1: ready_pct = 100;
                    2: ready_pct = 60;
                    default: ready_pct = 25;
                endcase
                stretch = $urandom_range(16, 80);
            end
            stretch--;
            res_if.ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // compare each answer transfer with the oldest prediction
    always @(posedge clk)
    begin
        sched_answer_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (answers_due.size() == 0)
            begin
                $error("answer with none expected: dispatch %0b next %0h removed %0b status %0d",
                       res_if.dispatch_valid, res_if.next_thread, res_if.was_removed,
                       res_if.status);
                fail_cnt++;
            end
            else
            begin
                want = answers_due.pop_front();
                checked_cnt++;
                if (res_if.dispatch_valid !== want.dispatch_valid)
                begin
                    $error("dispatch_valid: expected %0b, got %0b",
                           want.dispatch_valid, res_if.dispatch_valid);
                    fail_cnt++;
                end
                if (res_if.next_thread !== want.next_thread)
                begin
                    $error("next_thread: expected %0h, got %0h",
                           want.next_thread, res_if.next_thread);
                    fail_cnt++;
                end
                if (res_if.was_removed !== want.was_removed)
                begin
                    $error("was_removed: expected %0b, got %0b",
                           want.was_removed, res_if.was_removed);
                    fail_cnt++;
                end
                if (res_if.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res_if.status);
                    fail_cnt++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        sched_action_t a;
        int pick;
        rst_n              = 1'b0;
        item_if.valid      = 1'b0;
        item_if.action     = ACT_ENQUEUE;
        item_if.thread_id  = '0;
        item_if.current_id = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        ready_q.delete();
        yield_tid    = '0;
        yielder_seen = 1'b0;
        idle_tid     = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows
        for (int i = 0; i < DIR_ROWS; i++)
            send_action(dir_rows[i].act, dir_rows[i].typed, dir_rows[i].answer);
        drain_block();

        // random phases, each under its own idle thread
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_idle(PHASE_IDLE[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < PHASE_ENQ_PCT[p])
                    a.action = ACT_ENQUEUE;
                else
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                        a.action = ACT_YIELD;
                    else if (pick < 7)
                        a.action = ACT_TERM_OTHER;
                    else
                        a.action = ACT_TERM_SELF;
                end
                a.thread_id  = pick_id();
                a.current_id = pick_id();
                send_action(a, 1'b0, '0);
            end
            // hold off until every answer of the phase is back
            drain_block();
        end

        $display("%0d actions: %0d enqueue, %0d yield, %0d terminate-other, %0d terminate-self",
                 act_cnt[0] + act_cnt[1] + act_cnt[2] + act_cnt[3],
                 act_cnt[0], act_cnt[1], act_cnt[2], act_cnt[3]);
        $display("%0d answers checked, %0d full-queue drops, %0d idle ignores, %0d idle writes",
                 checked_cnt, full_drops, idle_ignores, cfg_writes);
        if (fail_cnt == 0 && answers_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/frq_pkg.sv
hw/rtl/frq_if.sv
hw/rtl/frq_cell.sv
hw/rtl/frq_cell_chain.sv
hw/rtl/fifo_ready_queue_scheduler_core.sv
verif/tb_top.sv
